/* rtl/ecc_pkg.sv */
// Shared types, constants and codes for the elevator collective controller.
`timescale 1ns / 1ps

package ecc_pkg;

    localparam int FLOORS       = 5;
    localparam int CAR_CAPACITY = 8;
    localparam int TAG_WIDTH    = 8;
    localparam int RIDER_WEIGHT = 70;

    localparam int MODE_W   = 3;
    localparam int FLOOR_W  = 3;
    localparam int DEST_W   = 3;
    localparam int DIR_W    = 2;
    localparam int PSTATE_W = 2;
    localparam int SLOT_AW  = (CAR_CAPACITY > 1) ? $clog2(CAR_CAPACITY) : 1;
    localparam int COUNT_W  = 4;
    localparam int WEIGHT_W = 10;
    localparam int IDX_W    = (COUNT_W > FLOOR_W) ? COUNT_W : FLOOR_W;

    typedef logic [FLOORS-1:0]    floor_vec_t;
    typedef logic [FLOOR_W-1:0]   floor_t;
    typedef logic [DEST_W-1:0]    dest_t;
    typedef logic [TAG_WIDTH-1:0] tag_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [SLOT_AW-1:0]   slot_addr_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_DOWN = 2'd0,
        DIR_STOP = 2'd1,
        DIR_UP   = 2'd2
    } dir_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CALL       = 3'd0,
        MODE_BOARD      = 3'd1,
        MODE_ALIGHT     = 3'd2,
        MODE_START_IDLE = 3'd3,
        MODE_MOVE       = 3'd4
    } mode_t;

    typedef enum logic [PSTATE_W-1:0] {
        PS_NEW     = 2'd0,
        PS_WAITING = 2'd1,
        PS_RIDING  = 2'd2,
        PS_ARRIVED = 2'd3
    } pstate_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_AL_COUNT,
        ST_AL_EMIT,
        ST_UP_SCAN,
        ST_DN_SCAN,
        ST_STEP,
        ST_MV_UP,
        ST_MV_DN,
        ST_RESTORE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        floor_t     floor;
        dir_t       direction;
        floor_vec_t up_calls;
        floor_vec_t down_calls;
        floor_vec_t car_targets;
        count_t     rider_count;
    } status_t;

    typedef struct packed {
        logic emit;
        tag_t tag;
        logic valid;
        logic last;
        logic boarded;
        logic bad;
    } result_t;

    typedef struct packed {
        logic       en;
        slot_addr_t addr;
        tag_t       tag;
        dest_t      dest;
    } slot_wr_t;

endpackage

/* rtl/ecc_slot_file.sv */
// Rider slot storage: tag and destination per car slot, one write, one read.
`timescale 1ns / 1ps

module ecc_slot_file (
    input  logic               clk,
    input  ecc_pkg::slot_wr_t  wr,
    input  ecc_pkg::slot_addr_t rd_addr,
    output ecc_pkg::tag_t      rd_tag,
    output ecc_pkg::dest_t     rd_dest
);
    import ecc_pkg::*;

    tag_t  tags_reg  [CAR_CAPACITY];
    dest_t dests_reg [CAR_CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tags_reg[wr.addr]  <= wr.tag;
            dests_reg[wr.addr] <= wr.dest;
        end
    end

    assign rd_tag  = tags_reg[rd_addr];
    assign rd_dest = dests_reg[rd_addr];

endmodule

/* rtl/ecc_ctrl.sv */
// Sequencer and car state: one scan index and compare unit walks floors or slots.
`timescale 1ns / 1ps

module ecc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ecc_pkg::MODE_W-1:0]    mode,
    input  logic [ecc_pkg::FLOOR_W-1:0]   start_floor,
    input  logic [ecc_pkg::DEST_W-1:0]    dest_floor,
    input  logic [ecc_pkg::TAG_WIDTH-1:0] passenger_tag,
    input  logic [ecc_pkg::PSTATE_W-1:0]  passenger_state,
    output logic                          busy,
    output ecc_pkg::status_t              status,
    output ecc_pkg::result_t              result,
    output ecc_pkg::slot_wr_t             slot_wr,
    output ecc_pkg::slot_addr_t           rd_addr,
    input  ecc_pkg::tag_t                 rd_tag,
    input  ecc_pkg::dest_t                rd_dest
);
    import ecc_pkg::*;

    localparam int SCAN_W = 1 << FLOOR_W;

    state_t     state_reg, state_next;
    floor_t     floor_reg, floor_next;
    dir_t       dir_reg, dir_next;
    floor_t     goal_reg, goal_next;
    floor_vec_t up_reg, up_next;
    floor_vec_t down_reg, down_next;
    floor_vec_t tgt_reg, tgt_next;
    count_t     occ_reg, occ_next;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    floor_t              start_reg, start_next;
    dest_t               dest_reg, dest_next;
    tag_t                tag_reg, tag_next;
    logic [PSTATE_W-1:0] pstate_reg, pstate_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    count_t              lim_reg, lim_next;
    count_t              keep_reg, keep_next;
    count_t              nleft_reg, nleft_next;
    count_t              sent_reg, sent_next;
    logic                boarded_reg, boarded_next;
    logic                bad_reg, bad_next;

    // shared scan unit
    floor_vec_t          scan_vec;
    logic [SCAN_W-1:0]   scan_pad;
    floor_t              fidx;
    logic                bit_hit;
    logic                at_top;
    logic                at_ground;
    logic                idx_lt_lim;
    logic                dest_here;
    dir_t                pdir;

    always_comb
    begin
        unique case (state_reg)
            ST_UP_SCAN: scan_vec = up_reg;
            ST_DN_SCAN: scan_vec = down_reg;
            ST_MV_UP:   scan_vec = tgt_reg | up_reg;
            ST_MV_DN:   scan_vec = tgt_reg | down_reg;
            default:    scan_vec = '0;
        endcase
    end

    assign scan_pad   = SCAN_W'(scan_vec);
    assign fidx       = idx_reg[FLOOR_W-1:0];
    assign bit_hit    = scan_pad[fidx];
    assign at_top     = (fidx == FLOOR_W'(FLOORS - 1));
    assign at_ground  = (fidx == '0);
    assign idx_lt_lim = (idx_reg < IDX_W'(lim_reg));
    assign dest_here  = (rd_dest == DEST_W'(floor_reg));
    assign pdir       = (DEST_W'(start_reg) < dest_reg) ? DIR_UP : DIR_DOWN;
    assign rd_addr    = idx_reg[SLOT_AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_DECODE;
            ST_DECODE:
            begin
                unique case (mode_t'(mode_reg))
                    MODE_CALL, MODE_BOARD: state_next = ST_REPORT;
                    MODE_ALIGHT:           state_next = ST_AL_COUNT;
                    MODE_START_IDLE:
                        priority if (dir_reg != DIR_STOP) state_next = ST_REPORT;
                        else if (up_reg != '0)            state_next = ST_UP_SCAN;
                        else if (down_reg != '0)          state_next = ST_DN_SCAN;
                        else                              state_next = ST_REPORT;
                    MODE_MOVE:
                        priority if (dir_reg == DIR_UP)
                            state_next = (floor_reg == FLOOR_W'(FLOORS - 1)) ?
                                         ST_RESTORE : ST_MV_UP;
                        else if (dir_reg == DIR_DOWN)
                            state_next = (floor_reg == '0) ? ST_RESTORE : ST_MV_DN;
                        else
                            state_next = ST_RESTORE;
                    default: state_next = ST_REPORT;
                endcase
            end
            ST_AL_COUNT:
                if (!idx_lt_lim)
                    state_next = (nleft_reg == '0) ? ST_REPORT : ST_AL_EMIT;
            ST_AL_EMIT:
                if (!idx_lt_lim)
                    state_next = ST_IDLE;
            ST_UP_SCAN:
                if (bit_hit || at_top)
                    state_next = ST_STEP;
            ST_DN_SCAN:
                if (bit_hit || at_ground)
                    state_next = ST_STEP;
            ST_STEP:
                state_next = ST_REPORT;
            ST_MV_UP:
                priority if (bit_hit) state_next = ST_REPORT;
                else if (at_top)      state_next = ST_RESTORE;
                else                  state_next = ST_MV_UP;
            ST_MV_DN:
                priority if (bit_hit) state_next = ST_REPORT;
                else if (at_ground)   state_next = ST_RESTORE;
                else                  state_next = ST_MV_DN;
            ST_RESTORE:
                if (!idx_lt_lim)
                    state_next = ST_REPORT;
            ST_REPORT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        floor_next   = floor_reg;
        dir_next     = dir_reg;
        goal_next    = goal_reg;
        up_next      = up_reg;
        down_next    = down_reg;
        tgt_next     = tgt_reg;
        occ_next     = occ_reg;
        mode_next    = mode_reg;
        start_next   = start_reg;
        dest_next    = dest_reg;
        tag_next     = tag_reg;
        pstate_next  = pstate_reg;
        idx_next     = idx_reg;
        lim_next     = lim_reg;
        keep_next    = keep_reg;
        nleft_next   = nleft_reg;
        sent_next    = sent_reg;
        boarded_next = boarded_reg;
        bad_next     = bad_reg;
        result       = '0;
        slot_wr      = '0;

        unique case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    mode_next   = mode;
                    start_next  = start_floor;
                    dest_next   = dest_floor;
                    tag_next    = passenger_tag;
                    pstate_next = passenger_state;
                end
            ST_DECODE:
            begin
                boarded_next = 1'b0;
                bad_next     = 1'b0;
                lim_next     = occ_reg;
                idx_next     = '0;
                keep_next    = '0;
                nleft_next   = '0;
                sent_next    = '0;
                unique case (mode_t'(mode_reg))
                    MODE_CALL:
                        if ((pstate_t'(pstate_reg) == PS_NEW ||
                             pstate_t'(pstate_reg) == PS_WAITING) &&
                            start_reg < FLOOR_W'(FLOORS))
                        begin
                            if (pdir == DIR_UP)
                                up_next = up_reg | (floor_vec_t'(1) << start_reg);
                            else
                                down_next = down_reg | (floor_vec_t'(1) << start_reg);
                        end
                    MODE_BOARD:
                        if (occ_reg < COUNT_W'(CAR_CAPACITY) && floor_reg == start_reg &&
                            pstate_t'(pstate_reg) == PS_WAITING &&
                            (dir_reg == pdir || dir_reg == DIR_STOP))
                        begin
                            slot_wr.en   = 1'b1;
                            slot_wr.addr = occ_reg[SLOT_AW-1:0];
                            slot_wr.tag  = tag_reg;
                            slot_wr.dest = dest_reg;
                            occ_next     = occ_reg + COUNT_W'(1);
                            boarded_next = 1'b1;
                            if (dest_reg >= DEST_W'(FLOORS))
                                bad_next = 1'b1;
                            else
                            begin
                                if (pdir == DIR_UP)
                                    up_next = up_reg & ~(floor_vec_t'(1) << start_reg);
                                else
                                    down_next = down_reg & ~(floor_vec_t'(1) << start_reg);
                                tgt_next = tgt_reg | (floor_vec_t'(1) << dest_reg);
                            end
                        end
                    MODE_START_IDLE:
                        if (dir_reg == DIR_STOP)
                        begin
                            priority if (up_reg != '0)
                                idx_next = '0;
                            else if (down_reg != '0)
                                idx_next = IDX_W'(FLOORS - 1);
                            else if (occ_reg == '0 && floor_reg != '0)
                            begin
                                dir_next   = DIR_DOWN;
                                floor_next = floor_reg - FLOOR_W'(1);
                            end
                            else
                                floor_next = floor_reg;
                        end
                    MODE_MOVE:
                        priority if (dir_reg == DIR_UP && floor_reg != FLOOR_W'(FLOORS - 1))
                            idx_next = IDX_W'(floor_reg) + IDX_W'(1);
                        else if (dir_reg == DIR_DOWN && floor_reg != '0)
                            idx_next = IDX_W'(floor_reg) - IDX_W'(1);
                        else
                            idx_next = '0;
                    default: ;
                endcase
            end
            ST_AL_COUNT:
                if (idx_lt_lim)
                begin
                    if (dest_here)
                        nleft_next = nleft_reg + COUNT_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
                else
                begin
                    // commit final status before any leaver beat goes out
                    occ_next = lim_reg - nleft_reg;
                    if (nleft_reg != '0)
                        tgt_next = tgt_reg & ~(floor_vec_t'(1) << floor_reg);
                    idx_next  = '0;
                    keep_next = '0;
                    sent_next = '0;
                end
            ST_AL_EMIT:
                if (idx_lt_lim)
                begin
                    if (dest_here)
                    begin
                        result.emit  = 1'b1;
                        result.tag   = rd_tag;
                        result.valid = 1'b1;
                        result.last  = (sent_reg + COUNT_W'(1) == nleft_reg);
                        sent_next    = sent_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        // compact keepers toward slot zero
                        slot_wr.en   = 1'b1;
                        slot_wr.addr = keep_reg[SLOT_AW-1:0];
                        slot_wr.tag  = rd_tag;
                        slot_wr.dest = rd_dest;
                        keep_next    = keep_reg + COUNT_W'(1);
                    end
                    idx_next = idx_reg + IDX_W'(1);
                end
            ST_UP_SCAN:
                if (bit_hit || at_top)
                begin
                    goal_next = fidx;
                    dir_next  = DIR_UP;
                end
                else
                    idx_next = idx_reg + IDX_W'(1);
            ST_DN_SCAN:
                if (bit_hit || at_ground)
                begin
                    goal_next = fidx;
                    dir_next  = DIR_DOWN;
                end
                else
                    idx_next = idx_reg - IDX_W'(1);
            ST_STEP:
                priority if (floor_reg < goal_reg)
                    floor_next = floor_reg + FLOOR_W'(1);
                else if (floor_reg > goal_reg)
                    floor_next = floor_reg - FLOOR_W'(1);
                else
                    floor_next = floor_reg;
            ST_MV_UP:
                priority if (bit_hit) floor_next = floor_reg + FLOOR_W'(1);
                else if (at_top)      idx_next = '0;
                else                  idx_next = idx_reg + IDX_W'(1);
            ST_MV_DN:
                priority if (bit_hit) floor_next = floor_reg - FLOOR_W'(1);
                else if (at_ground)   idx_next = '0;
                else                  idx_next = idx_reg - IDX_W'(1);
            ST_RESTORE:
                if (idx_lt_lim)
                begin
                    if (rd_dest < DEST_W'(FLOORS))
                        tgt_next = tgt_next | (floor_vec_t'(1) << rd_dest);
                    idx_next = idx_reg + IDX_W'(1);
                end
                else
                    dir_next = DIR_STOP;
            ST_REPORT:
            begin
                result.emit    = 1'b1;
                result.last    = 1'b1;
                result.boarded = boarded_reg;
                result.bad     = bad_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            floor_reg <= '0;
            dir_reg   <= DIR_STOP;
            goal_reg  <= '0;
            up_reg    <= '0;
            down_reg  <= '0;
            tgt_reg   <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            floor_reg <= floor_next;
            dir_reg   <= dir_next;
            goal_reg  <= goal_next;
            up_reg    <= up_next;
            down_reg  <= down_next;
            tgt_reg   <= tgt_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        start_reg   <= start_next;
        dest_reg    <= dest_next;
        tag_reg     <= tag_next;
        pstate_reg  <= pstate_next;
        idx_reg     <= idx_next;
        lim_reg     <= lim_next;
        keep_reg    <= keep_next;
        nleft_reg   <= nleft_next;
        sent_reg    <= sent_next;
        boarded_reg <= boarded_next;
        bad_reg     <= bad_next;
    end

    assign busy               = (state_reg != ST_IDLE);
    assign status.floor       = floor_reg;
    assign status.direction   = dir_reg;
    assign status.up_calls    = up_reg;
    assign status.down_calls  = down_reg;
    assign status.car_targets = tgt_reg;
    assign status.rider_count = occ_reg;

endmodule

/* rtl/elevator_collective_controller_top.sv */
// Top level of the elevator collective controller: sequencer, slot file, result registers.
//
// Usage: drive mode and the passenger fields with start high while busy is low;
// that edge accepts the command beat. busy stays high until the command is done.
// Each result beat sits on the result ports for one cycle with result_strobe high;
// the receiver cannot stall, so every strobed beat must be taken as it comes.
// Call, board, unknown mode: one beat; the next command can be accepted at the
// edge that takes the final beat. Start if idle, when stopped with calls pending:
// floor scan by the shared index unit, then one step. Move: floor scan, then,
// if nothing lies ahead, slot scan to restore targets.
// Alight: a count pass over the occupied slots, then, if anyone leaves, an emit
// and compact pass; one beat per leaver in slot order, or one beat with
// alighted_valid low when nobody leaves.
// All beats of a command report the car status after the command; last marks
// the final beat. Reset puts the car stopped at the ground floor, empty, with
// no calls or targets; no clearing pass is needed.
`timescale 1ns / 1ps

module elevator_collective_controller_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ecc_pkg::MODE_W-1:0]    mode,
    input  logic [ecc_pkg::FLOOR_W-1:0]   start_floor,
    input  logic [ecc_pkg::DEST_W-1:0]    dest_floor,
    input  logic [ecc_pkg::TAG_WIDTH-1:0] passenger_tag,
    input  logic [ecc_pkg::PSTATE_W-1:0]  passenger_state,
    output logic                          result_strobe,
    output logic [ecc_pkg::FLOOR_W-1:0]   floor,
    output logic [ecc_pkg::DIR_W-1:0]     direction,
    output logic [ecc_pkg::FLOORS-1:0]    up_calls,
    output logic [ecc_pkg::FLOORS-1:0]    down_calls,
    output logic [ecc_pkg::FLOORS-1:0]    car_targets,
    output logic [ecc_pkg::COUNT_W-1:0]   rider_count,
    output logic [ecc_pkg::WEIGHT_W-1:0]  load_weight,
    output logic                          boarded,
    output logic                          bad_destination,
    output logic [ecc_pkg::TAG_WIDTH-1:0] alighted_tag,
    output logic                          alighted_valid,
    output logic                          last
);
    import ecc_pkg::*;

    status_t    status;
    result_t    result;
    slot_wr_t   slot_wr;
    slot_addr_t rd_addr;
    tag_t       rd_tag;
    dest_t      rd_dest;

    logic                strobe_reg;
    floor_t              floor_reg;
    logic [DIR_W-1:0]    direction_reg;
    floor_vec_t          up_reg;
    floor_vec_t          down_reg;
    floor_vec_t          tgt_reg;
    count_t              count_reg;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic                boarded_reg;
    logic                bad_reg;
    tag_t                atag_reg;
    logic                avalid_reg;
    logic                last_reg;

    ecc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .mode            (mode),
        .start_floor     (start_floor),
        .dest_floor      (dest_floor),
        .passenger_tag   (passenger_tag),
        .passenger_state (passenger_state),
        .busy            (busy),
        .status          (status),
        .result          (result),
        .slot_wr         (slot_wr),
        .rd_addr         (rd_addr),
        .rd_tag          (rd_tag),
        .rd_dest         (rd_dest)
    );

    ecc_slot_file u_slots (
        .clk     (clk),
        .wr      (slot_wr),
        .rd_addr (rd_addr),
        .rd_tag  (rd_tag),
        .rd_dest (rd_dest)
    );

    assign weight_next = WEIGHT_W'(status.rider_count) * WEIGHT_W'(RIDER_WEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= result.emit;
    end

    // hold the last beat on the payload ports between strobes
    always_ff @(posedge clk)
    begin
        if (result.emit)
        begin
            floor_reg     <= status.floor;
            direction_reg <= status.direction;
            up_reg        <= status.up_calls;
            down_reg      <= status.down_calls;
            tgt_reg       <= status.car_targets;
            count_reg     <= status.rider_count;
            weight_reg    <= weight_next;
            boarded_reg   <= result.boarded;
            bad_reg       <= result.bad;
            atag_reg      <= result.tag;
            avalid_reg    <= result.valid;
            last_reg      <= result.last;
        end
    end

    assign result_strobe   = strobe_reg;
    assign floor           = floor_reg;
    assign direction       = direction_reg;
    assign up_calls        = up_reg;
    assign down_calls      = down_reg;
    assign car_targets     = tgt_reg;
    assign rider_count     = count_reg;
    assign load_weight     = weight_reg;
    assign boarded         = boarded_reg;
    assign bad_destination = bad_reg;
    assign alighted_tag    = atag_reg;
    assign alighted_valid  = avalid_reg;
    assign last            = last_reg;

    a_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result beat without a command in progress");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (rider_count <= COUNT_W'(CAR_CAPACITY)))
        else $error("rider count above car capacity");

    a_alight_not_board: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && alighted_valid) |-> (!boarded && !bad_destination))
        else $error("alight beat flagged as board");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the elevator collective controller.
`timescale 1ns / 1ps

module tb_top;
    import ecc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNDEFINED = 3'd7;
    localparam int DRAIN_LIMIT = 2000;
    localparam int TAIL_CYCLES = 30;
    localparam int RANDOM_ITEMS = 130;

    typedef struct {
        floor_t                at_floor;
        dir_t                  heading;
        floor_vec_t            up_hall;
        floor_vec_t            down_hall;
        floor_vec_t            dest_set;
        count_t                riders;
        logic [WEIGHT_W-1:0]   weight;
        logic                  took;
        logic                  flagged;
        tag_t                  leaver;
        logic                  leaver_ok;
        logic                  final_beat;
    } car_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [MODE_W-1:0]     mode;
    logic [FLOOR_W-1:0]    start_floor;
    logic [DEST_W-1:0]     dest_floor;
    logic [TAG_WIDTH-1:0]  passenger_tag;
    logic [PSTATE_W-1:0]   passenger_state;
    logic                  result_strobe;
    logic [FLOOR_W-1:0]    floor;
    logic [DIR_W-1:0]      direction;
    logic [FLOORS-1:0]     up_calls;
    logic [FLOORS-1:0]     down_calls;
    logic [FLOORS-1:0]     car_targets;
    logic [COUNT_W-1:0]    rider_count;
    logic [WEIGHT_W-1:0]   load_weight;
    logic                  boarded;
    logic                  bad_destination;
    logic [TAG_WIDTH-1:0]  alighted_tag;
    logic                  alighted_valid;
    logic                  last;

    // predicted car state
    floor_t      car_at;
    dir_t        heading;
    floor_t      goal_at;
    floor_vec_t  up_hall;
    floor_vec_t  down_hall;
    floor_vec_t  car_dest_set;
    int          riders;
    tag_t        slot_tag [CAR_CAPACITY];
    dest_t       slot_dest [CAR_CAPACITY];

    car_report_t pending_reports [$];
    car_report_t due;
    int          errors;
    logic        gaps_on;

    elevator_collective_controller_top i_dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_report(input logic took, input logic flagged, input tag_t leaver,
                               input logic leaver_ok, input logic final_beat);
        car_report_t r;
        r.at_floor   = car_at;
        r.heading    = heading;
        r.up_hall    = up_hall;
        r.down_hall  = down_hall;
        r.dest_set   = car_dest_set;
        r.riders     = count_t'(riders);
        r.weight     = WEIGHT_W'(riders * RIDER_WEIGHT);
        r.took       = took;
        r.flagged    = flagged;
        r.leaver     = leaver;
        r.leaver_ok  = leaver_ok;
        r.final_beat = final_beat;
        pending_reports.insert(pending_reports.size(), r);
    endtask

    task automatic predict_car_step(input logic [MODE_W-1:0] md, input floor_t sf,
                                    input dest_t df, input tag_t tg, input pstate_t ps);
        dir_t       want_dir;
        floor_vec_t ahead;
        tag_t       leavers [$];
        int         keep;
        logic       did_move;
        logic       took;
        logic       flagged;
        want_dir = (sf < df) ? DIR_UP : DIR_DOWN;
        took     = 1'b0;
        flagged  = 1'b0;
        case (md)
            MODE_CALL:
                if ((ps == PS_NEW || ps == PS_WAITING) && sf < FLOORS)
                begin
                    if (want_dir == DIR_UP)
                        up_hall[sf] = 1'b1;
                    else
                        down_hall[sf] = 1'b1;
                end
            MODE_BOARD:
                if (riders < CAR_CAPACITY && car_at == sf && ps == PS_WAITING &&
                    (heading == want_dir || heading == DIR_STOP))
                begin
                    slot_tag[riders]  = tg;
                    slot_dest[riders] = df;
                    riders++;
                    took = 1'b1;
                    if (df >= FLOORS)
                        flagged = 1'b1;
                    else
                    begin
                        if (want_dir == DIR_UP)
                            up_hall[sf] = 1'b0;
                        else
                            down_hall[sf] = 1'b0;
                        car_dest_set[df] = 1'b1;
                    end
                end
            MODE_ALIGHT:
            begin
                // drop leavers, compact the rest in slot order
                keep = 0;
                for (int i = 0; i < riders; i++)
                begin
                    if (slot_dest[i] == car_at)
                        leavers.insert(leavers.size(), slot_tag[i]);
                    else
                    begin
                        slot_tag[keep]  = slot_tag[i];
                        slot_dest[keep] = slot_dest[i];
                        keep++;
                    end
                end
                riders = keep;
                if (leavers.size() != 0)
                    car_dest_set[car_at] = 1'b0;
            end
            MODE_START_IDLE:
                if (heading == DIR_STOP)
                begin
                    if (up_hall != '0)
                    begin
                        for (int i = FLOORS - 1; i >= 0; i--)
                            if (up_hall[i])
                                goal_at = floor_t'(i);
                        heading = DIR_UP;
                        if (car_at < goal_at) car_at++; else if (car_at > goal_at) car_at--;
                    end
                    else if (down_hall != '0)
                    begin
                        for (int i = 0; i < FLOORS; i++)
                            if (down_hall[i])
                                goal_at = floor_t'(i);
                        heading = DIR_DOWN;
                        if (car_at < goal_at) car_at++; else if (car_at > goal_at) car_at--;
                    end
                    else if (riders == 0 && car_at != 0)
                    begin
                        heading = DIR_DOWN;
                        car_at--;
                    end
                end
            MODE_MOVE:
            begin
                did_move = 1'b0;
                if (heading == DIR_UP)
                begin
                    ahead = car_dest_set | up_hall;
                    for (int i = 0; i < FLOORS; i++)
                        if (i > car_at && ahead[i])
                            did_move = 1'b1;
                    if (did_move)
                        car_at++;
                end
                else if (heading == DIR_DOWN)
                begin
                    ahead = car_dest_set | down_hall;
                    for (int i = 0; i < FLOORS; i++)
                        if (i < car_at && ahead[i])
                            did_move = 1'b1;
                    if (did_move)
                        car_at--;
                end
                if (!did_move)
                begin
                    // nothing ahead: restore rider targets and stop
                    for (int i = 0; i < riders; i++)
                        if (slot_dest[i] < FLOORS)
                            car_dest_set[slot_dest[i]] = 1'b1;
                    heading = DIR_STOP;
                end
            end
            default: ;
        endcase
        if (leavers.size() == 0)
            push_report(took, flagged, '0, 1'b0, 1'b1);
        else
            foreach (leavers[k])
                push_report(1'b0, 1'b0, leavers[k], 1'b1, k == leavers.size() - 1);
    endtask

    function automatic int count_stranded();
        int n;
        n = 0;
        for (int i = 0; i < riders; i++)
            if (slot_dest[i] >= FLOORS)
                n++;
        return n;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, floor %0d tag %0d",
                         $time, floor, alighted_tag);
                errors++;
            end
            else
            begin
                due = pending_reports.pop_front();
                check_field("floor", due.at_floor, floor);
                check_field("direction", due.heading, direction);
                check_field("up_calls", due.up_hall, up_calls);
                check_field("down_calls", due.down_hall, down_calls);
                check_field("car_targets", due.dest_set, car_targets);
                check_field("rider_count", due.riders, rider_count);
                check_field("load_weight", due.weight, load_weight);
                check_field("boarded", due.took, boarded);
                check_field("bad_destination", due.flagged, bad_destination);
                check_field("alighted_tag", due.leaver, alighted_tag);
                check_field("alighted_valid", due.leaver_ok, alighted_valid);
                check_field("last", due.final_beat, last);
            end
        end
    end

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Hold the command beat until the block takes it, then predict its results.
    task automatic send_command(input logic [MODE_W-1:0] md, input floor_t sf, input dest_t df,
                                input tag_t tg, input pstate_t ps);
        if (gaps_on && $urandom_range(0, 99) < 25)
            idle_cycles($urandom_range(1, 6));
        @(negedge clk);
        start           <= 1'b1;
        mode            <= md;
        start_floor     <= sf;
        dest_floor      <= df;
        passenger_tag   <= tg;
        passenger_state <= ps;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_car_step(md, sf, df, tg, ps);
    endtask

    // Lower start and wait for every expected beat, with a limit.
    task automatic drain_reports();
        int n;
        @(negedge clk);
        start <= 1'b0;
        n = 0;
        while ((pending_reports.size() != 0 || busy) && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (pending_reports.size() != 0)
        begin
            $display("%0t: %0d expected result beats never arrived", $time,
                     pending_reports.size());
            errors += pending_reports.size();
            pending_reports.delete();
        end
    endtask

    task automatic test_hall_calls();
        send_command(MODE_CALL, 3'd1, 3'd3, 8'h11, PS_NEW);
        send_command(MODE_CALL, 3'd2, 3'd0, 8'h22, PS_ARRIVED);
        send_command(MODE_CALL, 3'd7, 3'd0, 8'h33, PS_NEW);
    endtask

    task automatic test_trip_up();
        send_command(MODE_START_IDLE, '0, '0, tag_t'($urandom), PS_NEW);
        send_command(MODE_BOARD, 3'd1, 3'd2, 8'hFF, PS_WAITING);
        send_command(MODE_MOVE, '0, '0, tag_t'($urandom), PS_NEW);
        send_command(MODE_ALIGHT, '0, '0, tag_t'($urandom), PS_NEW);
        send_command(MODE_MOVE, '0, '0, tag_t'($urandom), PS_NEW);
    endtask

    task automatic test_empty_return();
        send_command(MODE_START_IDLE, '0, '0, tag_t'($urandom), PS_NEW);
        send_command(MODE_ALIGHT, '0, '0, tag_t'($urandom), PS_NEW);
        send_command(MODE_MOVE, '0, '0, tag_t'($urandom), PS_NEW);
    endtask

    task automatic test_trip_down();
        send_command(MODE_CALL, 3'd1, 3'd0, 8'h44, PS_WAITING);
        send_command(MODE_START_IDLE, '0, '0, tag_t'($urandom), PS_NEW);
        send_command(MODE_BOARD, 3'd1, 3'd0, 8'h00, PS_WAITING);
        // going up while the car heads down: refused
        send_command(MODE_BOARD, 3'd1, 3'd4, 8'h3C, PS_WAITING);
    endtask

    task automatic test_full_car();
        dest_t fill_dest [7] = '{3'd1, 3'd0, 3'd1, 3'd1, 3'd0, 3'd1, 3'd0};
        foreach (fill_dest[i])
            send_command(MODE_BOARD, 3'd1, fill_dest[i], tag_t'($urandom), PS_WAITING);
        send_command(MODE_BOARD, 3'd1, 3'd1, tag_t'($urandom), PS_WAITING);
        send_command(MODE_ALIGHT, '0, '0, tag_t'($urandom), PS_NEW);
        send_command(MODE_MOVE, '0, '0, tag_t'($urandom), PS_NEW);
        send_command(MODE_ALIGHT, '0, '0, tag_t'($urandom), PS_NEW);
        send_command(MODE_MOVE, '0, '0, tag_t'($urandom), PS_NEW);
    endtask

    task automatic test_odd_commands();
        send_command(MODE_BOARD, 3'd0, 3'd7, tag_t'($urandom), PS_WAITING);
        send_command(MODE_UNDEFINED, 3'd7, 3'd7, 8'hFF, PS_ARRIVED);
    endtask

    task automatic random_command();
        int                pick;
        logic [MODE_W-1:0] md;
        floor_t            sf;
        dest_t             df;
        pstate_t           ps;
        pick = $urandom_range(0, 99);
        sf   = floor_t'($urandom_range(0, FLOORS - 1));
        df   = dest_t'($urandom_range(0, FLOORS - 1));
        ps   = PS_WAITING;
        if (pick < 20)
        begin
            md = MODE_CALL;
            if ($urandom_range(0, 3) == 0)
                ps = pstate_t'($urandom_range(2, 3));
            else
                ps = pstate_t'($urandom_range(0, 1));
        end
        else if (pick < 45)
        begin
            // mostly boards that can succeed: right floor, waiting, matching direction
            md = MODE_BOARD;
            if ($urandom_range(0, 6) != 0)
                sf = car_at;
            if ($urandom_range(0, 6) == 0)
                ps = pstate_t'($urandom_range(0, 3));
            if (count_stranded() < 2 && $urandom_range(0, 14) == 0)
                df = dest_t'($urandom_range(FLOORS, 7));
            else if ($urandom_range(0, 9) < 7)
            begin
                if (heading == DIR_UP && sf < FLOORS - 1)
                    df = dest_t'($urandom_range(sf + 1, FLOORS - 1));
                else if (heading == DIR_DOWN)
                    df = dest_t'($urandom_range(0, sf));
            end
        end
        else if (pick < 60)
            md = MODE_ALIGHT;
        else if (pick < 70)
            md = MODE_START_IDLE;
        else if (pick < 95)
            md = MODE_MOVE;
        else
        begin
            md = MODE_W'($urandom_range(0, 7));
            sf = floor_t'($urandom_range(0, 7));
            df = dest_t'($urandom_range(0, 7));
            ps = pstate_t'($urandom_range(0, 3));
        end
        send_command(md, sf, df, tag_t'($urandom), ps);
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // no idling in the middle stretch
            gaps_on = (n < 60 || n >= 110);
            if (n == 80)
                drain_reports();
            random_command();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        mode            = '0;
        start_floor     = '0;
        dest_floor      = '0;
        passenger_tag   = '0;
        passenger_state = '0;
        errors          = 0;
        gaps_on         = 1'b1;
        car_at          = '0;
        heading         = DIR_STOP;
        goal_at         = '0;
        up_hall         = '0;
        down_hall       = '0;
        car_dest_set    = '0;
        riders          = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_hall_calls();
        test_trip_up();
        test_empty_return();
        test_trip_down();
        test_full_car();
        test_odd_commands();
        drain_reports();
        test_random_traffic();
        drain_reports();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
